[hdl/civil_date_day_count_converter_unit_assert.svh]
// ============================================================================
// Assertion macros for the civil date converter
// Two checking forms: an implication checked in the same cycle and an invariant.
// ============================================================================
`ifndef CIVIL_DATE_DAY_COUNT_CONVERTER_UNIT_ASSERT_SVH
`define CIVIL_DATE_DAY_COUNT_CONVERTER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CDCU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("civil date converter: implication check failed");
`define CDCU_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("civil date converter: invariant check failed");
`else
`define CDCU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CDCU_ASSERT_ALWAYS(label, clk, rst_n, expr)
`endif
`endif

[hdl/cdconv_pkg.sv]
// ============================================================================
// Civil date converter package
// Shared widths, constants, status codes, result structs and the month table.
// ============================================================================
package cdconv_pkg;

    // Field widths.
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 22;

    // Calendar constants.
    localparam logic [COUNT_W-1:0] MAX_COUNT     = 22'd2958463;
    localparam logic [YEAR_W-1:0]  MAX_YEAR      = 14'd9999;
    localparam logic [MONTH_W-1:0] MAX_MONTH     = 4'd12;
    localparam logic [DAY_W-1:0]   MAX_DAY       = 5'd31;
    localparam logic [YEAR_W-1:0]  FIRST_YEAR    = 14'd1900;
    // Days from 0000-03-01 up to the base date 1900-01-01.
    localparam logic [COUNT_W-1:0] DAYS_TO_BASE  = 22'd693901;
    localparam logic [17:0]        DAYS_PER_ERA  = 18'd146097;
    localparam logic [8:0]         YEARS_PER_ERA = 9'd400;
    localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;

    // Reciprocals for division by constants.
    // x / 25 for x < 1024: (x * 1311) >> 15.
    localparam logic [10:0] RECIP_25   = 11'd1311;
    // z / 146097 for z < 2^22: (z * 15051803) >> 41.
    localparam logic [23:0] RECIP_ERA  = 24'd15051803;
    // x / 365 for x < 36525 (used as doe / 1460 on doe >> 2): (x * 22983) >> 23.
    localparam logic [14:0] RECIP_1460 = 15'd22983;
    // t / 365 for t < 2^18: (t * 183860) >> 26.
    localparam logic [17:0] RECIP_YEAR = 18'd183860;

    // Pipeline depths in register stages.
    localparam int FROM_STAGES = 7;
    localparam int TO_STAGES   = 3;
    localparam int PAD_STAGES  = FROM_STAGES - TO_STAGES;
    localparam int LATENCY     = FROM_STAGES + 1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEFORE = 2'd1,
        ST_BEYOND = 2'd2
    } t_status;

    // Result of the date to day count path.
    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   days;
    } t_days_res;

    // Result of the day count to date path.
    typedef struct packed {
        logic                 sat;
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
    } t_date_res;

    // First day of each month within a March-based year, month 0 being March.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            4'd12:   v = 9'd367;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/cdconv_to_days.sv]
// ============================================================================
// Date to day count pipeline
// Three register stages: era split, year of era, day of era, then the final
// offset and range check on the registered outputs of the last stage.
// ============================================================================
module cdconv_to_days (
    input  logic                          i_clk,
    input  logic [cdconv_pkg::YEAR_W-1:0] i_year,
    input  logic [cdconv_pkg::MONTH_W-1:0] i_month,
    input  logic [cdconv_pkg::DAY_W-1:0]  i_day,
    output cdconv_pkg::t_days_res         o_res
);

    // Stage 1: shift to a March-based year and split off the era.
    logic                w_early;
    logic [14:0]         w_yp;
    logic [3:0]          w_mp;
    logic signed [9:0]   w_doy;
    logic [20:0]         w_era_prod;

    logic [13:0]         r1_y;
    logic                r1_neg;
    logic signed [9:0]   r1_doy;
    logic [5:0]          r1_era;

    always_comb begin
        w_early    = (i_month <= 4'd2);
        w_yp       = {1'b0, i_year} - {14'd0, w_early};
        w_mp       = w_early ? (i_month + 4'd9) : (i_month - 4'd3);
        w_doy      = $signed({1'b0, cdconv_pkg::month_start(w_mp)})
                   + $signed({5'd0, i_day}) - 10'sd1;
        w_era_prod = w_yp[13:4] * cdconv_pkg::RECIP_25;
    end

    always_ff @(posedge i_clk) begin
        r1_y   <= w_yp[13:0];
        // A borrow out of year zero means a date before any era we cover.
        r1_neg <= w_yp[14];
        r1_doy <= w_doy;
        r1_era <= w_era_prod[20:15];
    end

    // Stage 2: year of era and the days of the whole eras.
    logic [14:0]         w_era400;
    logic [13:0]         w_yoe_full;
    logic [22:0]         w_erad;

    logic [8:0]          r2_yoe;
    logic [22:0]         r2_erad;
    logic signed [9:0]   r2_doy;
    logic                r2_neg;

    always_comb begin
        w_era400   = r1_era * cdconv_pkg::YEARS_PER_ERA;
        w_yoe_full = r1_y - w_era400[13:0];
        w_erad     = r1_era * cdconv_pkg::DAYS_PER_ERA;
    end

    always_ff @(posedge i_clk) begin
        r2_yoe  <= w_yoe_full[8:0];
        r2_erad <= w_erad;
        r2_doy  <= r1_doy;
        r2_neg  <= r1_neg;
    end

    // Stage 3: day of era, which is negative only for day zero of March in
    // the first year of an era.
    logic [17:0]         w_yoe365;
    logic [1:0]          w_c100;
    logic signed [18:0]  w_doe;

    logic signed [18:0]  r3_doe;
    logic [22:0]         r3_erad;
    logic                r3_neg;

    always_comb begin
        w_yoe365 = r2_yoe * cdconv_pkg::DAYS_PER_YEAR;
        w_c100   = {1'b0, (r2_yoe >= 9'd100)} + {1'b0, (r2_yoe >= 9'd200)}
                 + {1'b0, (r2_yoe >= 9'd300)};
        w_doe    = $signed({1'b0, w_yoe365}) + $signed({12'd0, r2_yoe[8:2]})
                 - $signed({17'd0, w_c100}) + 19'(r2_doy);
    end

    always_ff @(posedge i_clk) begin
        r3_doe  <= w_doe;
        r3_erad <= r2_erad;
        r3_neg  <= r2_neg;
    end

    // Offset to the base date and range check.
    logic signed [24:0]  w_n;

    always_comb begin
        w_n = $signed({2'b0, r3_erad}) + 25'(r3_doe)
            - $signed({3'b0, cdconv_pkg::DAYS_TO_BASE});
        if (r3_neg || (w_n < 25'sd0)) begin
            o_res.status = cdconv_pkg::ST_BEFORE;
            o_res.days   = '0;
        end else if (w_n > $signed({3'b0, cdconv_pkg::MAX_COUNT})) begin
            o_res.status = cdconv_pkg::ST_BEYOND;
            o_res.days   = cdconv_pkg::MAX_COUNT;
        end else begin
            o_res.status = cdconv_pkg::ST_OK;
            o_res.days   = w_n[21:0];
        end
    end

endmodule

[hdl/cdconv_from_days.sv]
// ============================================================================
// Day count to date pipeline
// Seven register stages: offset, era, day of era, year correction, year of
// era, day of year, month search; the date is assembled after the last one.
// ============================================================================
module cdconv_from_days (
    input  logic                           i_clk,
    input  logic [cdconv_pkg::COUNT_W-1:0] i_day_count,
    output cdconv_pkg::t_date_res          o_res
);

    // Stage 1: count from 0000-03-01.
    logic [21:0] r1_z;
    logic        r1_sat;

    always_ff @(posedge i_clk) begin
        r1_z   <= i_day_count + cdconv_pkg::DAYS_TO_BASE;
        r1_sat <= (i_day_count > cdconv_pkg::MAX_COUNT);
    end

    // Stage 2: era number by reciprocal multiplication.
    logic [45:0] w_era_prod;
    logic [4:0]  r2_era;
    logic [21:0] r2_z;
    logic        r2_sat;

    assign w_era_prod = r1_z * cdconv_pkg::RECIP_ERA;

    always_ff @(posedge i_clk) begin
        r2_era <= w_era_prod[45:41];
        r2_z   <= r1_z;
        r2_sat <= r1_sat;
    end

    // Stage 3: day of era and the first year of the era.
    logic [22:0] w_erad;
    logic [22:0] w_doe_full;
    logic [13:0] w_y400;
    logic [17:0] r3_doe;
    logic [13:0] r3_y400;
    logic        r3_sat;

    always_comb begin
        w_erad     = r2_era * cdconv_pkg::DAYS_PER_ERA;
        w_doe_full = {1'b0, r2_z} - w_erad;
        w_y400     = r2_era * cdconv_pkg::YEARS_PER_ERA;
    end

    always_ff @(posedge i_clk) begin
        r3_doe  <= w_doe_full[17:0];
        r3_y400 <= w_y400;
        r3_sat  <= r2_sat;
    end

    // Stage 4: take out leap days so that a plain division by 365 gives the
    // year of era.
    logic [30:0] w_q_prod;
    logic [7:0]  w_q1460;
    logic [2:0]  w_q36524;
    logic        w_last;
    logic [18:0] w_t_full;
    logic [17:0] r4_t;
    logic [17:0] r4_doe;
    logic [13:0] r4_y400;
    logic        r4_sat;

    always_comb begin
        w_q_prod = r3_doe[17:2] * cdconv_pkg::RECIP_1460;
        w_q1460  = w_q_prod[30:23];
        w_q36524 = {2'b0, (r3_doe >= 18'd36524)} + {2'b0, (r3_doe >= 18'd73048)}
                 + {2'b0, (r3_doe >= 18'd109572)} + {2'b0, (r3_doe >= 18'd146096)};
        w_last   = (r3_doe == 18'd146096);
        w_t_full = {1'b0, r3_doe} - {11'd0, w_q1460} + {16'd0, w_q36524}
                 - {18'd0, w_last};
    end

    always_ff @(posedge i_clk) begin
        r4_t    <= w_t_full[17:0];
        r4_doe  <= r3_doe;
        r4_y400 <= r3_y400;
        r4_sat  <= r3_sat;
    end

    // Stage 5: year of era.
    logic [35:0] w_yoe_prod;
    logic [8:0]  r5_yoe;
    logic [17:0] r5_doe;
    logic [13:0] r5_y400;
    logic        r5_sat;

    assign w_yoe_prod = r4_t * cdconv_pkg::RECIP_YEAR;

    always_ff @(posedge i_clk) begin
        r5_yoe  <= w_yoe_prod[34:26];
        r5_doe  <= r4_doe;
        r5_y400 <= r4_y400;
        r5_sat  <= r4_sat;
    end

    // Stage 6: day of the March-based year.
    logic [17:0] w_yoe365;
    logic [1:0]  w_c100;
    logic [17:0] w_doy_full;
    logic [8:0]  r6_doy;
    logic [8:0]  r6_yoe;
    logic [13:0] r6_y400;
    logic        r6_sat;

    always_comb begin
        w_yoe365   = r5_yoe * cdconv_pkg::DAYS_PER_YEAR;
        w_c100     = {1'b0, (r5_yoe >= 9'd100)} + {1'b0, (r5_yoe >= 9'd200)}
                   + {1'b0, (r5_yoe >= 9'd300)};
        w_doy_full = r5_doe - (w_yoe365 + {11'd0, r5_yoe[8:2]} - {16'd0, w_c100});
    end

    always_ff @(posedge i_clk) begin
        r6_doy  <= w_doy_full[8:0];
        r6_yoe  <= r5_yoe;
        r6_y400 <= r5_y400;
        r6_sat  <= r5_sat;
    end

    // Stage 7: the month is the number of month starts after March's at or below the day.
    logic [3:0]  w_mp;
    logic [3:0]  r7_mp;
    logic [8:0]  r7_doy;
    logic [8:0]  r7_yoe;
    logic [13:0] r7_y400;
    logic        r7_sat;

    always_comb begin
        w_mp = 4'd0;
        for (int k = 1; k < 12; k++) begin
            w_mp = w_mp + {3'd0, (r6_doy >= cdconv_pkg::month_start(4'(k)))};
        end
    end

    always_ff @(posedge i_clk) begin
        r7_mp   <= w_mp;
        r7_doy  <= r6_doy;
        r7_yoe  <= r6_yoe;
        r7_y400 <= r6_y400;
        r7_sat  <= r6_sat;
    end

    // Date assembly; January and February belong to the next civil year.
    logic [8:0]  w_d_full;
    logic [3:0]  w_m;
    logic        w_jan_feb;

    always_comb begin
        w_d_full  = r7_doy - cdconv_pkg::month_start(r7_mp) + 9'd1;
        w_m       = (r7_mp < 4'd10) ? (r7_mp + 4'd3) : (r7_mp - 4'd9);
        w_jan_feb = (w_m <= 4'd2);
        o_res.sat = r7_sat;
        if (r7_sat) begin
            o_res.year  = cdconv_pkg::MAX_YEAR;
            o_res.month = cdconv_pkg::MAX_MONTH;
            o_res.day   = cdconv_pkg::MAX_DAY;
        end else begin
            o_res.year  = r7_y400 + {5'd0, r7_yoe} + {13'd0, w_jan_feb};
            o_res.month = w_m;
            o_res.day   = w_d_full[4:0];
        end
    end

endmodule

[hdl/civil_date_day_count_converter_unit.sv]
// ============================================================================
// Civil date and day count converter
// Converts a Gregorian date to days since 1900-01-01 and back, one request
// per clock while o_busy is low, fully pipelined.
// ============================================================================
// Usage:
// A request is taken at a rising clock edge where i_start is high and o_busy
// is low. i_req_type selects the direction: 0 converts i_year, i_month and
// i_day into a day count, 1 converts i_day_count into a date. Fields that the
// chosen direction does not use are ignored.
// Every request gives exactly one result. It is shown for one cycle with
// o_valid high; the receiver has no way to hold it off, and none is needed.
// A request passes the seven-stage day count to date pipeline or the date to
// day count path, then the output register. Throughput is one request per
// cycle while o_busy is low.
// The shorter date to day count path runs through four delay registers so
// both directions leave in request order at the same latency.
// o_busy is high only while i_rst_n is low and until the clock edge after it
// is released. Reset empties the pipeline; no result is emitted afterward
// for a request that was still in flight.
// Status: 0 ok, 1 date before the base date, 2 beyond 9999-12-31 (outputs
// saturate to the largest count or the last date).
// ============================================================================
`include "civil_date_day_count_converter_unit_assert.svh"

module civil_date_day_count_converter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_req_type,
    input  logic [cdconv_pkg::YEAR_W-1:0]   i_year,
    input  logic [cdconv_pkg::MONTH_W-1:0]  i_month,
    input  logic [cdconv_pkg::DAY_W-1:0]    i_day,
    input  logic [cdconv_pkg::COUNT_W-1:0]  i_day_count,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic [cdconv_pkg::COUNT_W-1:0]  o_days_out,
    output logic [cdconv_pkg::YEAR_W-1:0]   o_year_out,
    output logic [cdconv_pkg::MONTH_W-1:0]  o_month_out,
    output logic [cdconv_pkg::DAY_W-1:0]    o_day_out
);

    localparam int STAGES = cdconv_pkg::FROM_STAGES;
    localparam int PAD    = cdconv_pkg::PAD_STAGES;

    // The block is ready in the cycle after reset is released.
    logic r_run;
    logic w_accept;

    assign o_busy   = ~r_run;
    assign w_accept = i_start & r_run;

    // Both directions are computed for every request; the request type
    // travels with the valid bit and picks the result at the output.
    cdconv_pkg::t_days_res w_res0;
    cdconv_pkg::t_date_res w_res1;

    cdconv_to_days u_to_days (
        .i_clk   (i_clk),
        .i_year  (i_year),
        .i_month (i_month),
        .i_day   (i_day),
        .o_res   (w_res0)
    );

    cdconv_from_days u_from_days (
        .i_clk       (i_clk),
        .i_day_count (i_day_count),
        .o_res       (w_res1)
    );

    // Valid and request type shift lines, one bit per pipeline stage.
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] r_typ;

    // Delay line that brings the date to day count result level with the
    // other path.
    cdconv_pkg::t_days_res r_pad [PAD];

    // Output register.
    logic                            r_valid;
    logic [1:0]                      r_status;
    logic [cdconv_pkg::COUNT_W-1:0]  r_days;
    logic [cdconv_pkg::YEAR_W-1:0]   r_year;
    logic [cdconv_pkg::MONTH_W-1:0]  r_month;
    logic [cdconv_pkg::DAY_W-1:0]    r_day;

    logic [1:0]                      n_status;
    logic [cdconv_pkg::COUNT_W-1:0]  n_days;
    logic [cdconv_pkg::YEAR_W-1:0]   n_year;
    logic [cdconv_pkg::MONTH_W-1:0]  n_month;
    logic [cdconv_pkg::DAY_W-1:0]    n_day;

    always_comb begin
        if (r_typ[STAGES-1]) begin
            n_status = w_res1.sat ? cdconv_pkg::ST_BEYOND : cdconv_pkg::ST_OK;
            n_days   = '0;
            n_year   = w_res1.year;
            n_month  = w_res1.month;
            n_day    = w_res1.day;
        end else begin
            n_status = r_pad[PAD-1].status;
            n_days   = r_pad[PAD-1].days;
            n_year   = '0;
            n_month  = '0;
            n_day    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_run   <= 1'b1;
            r_vld   <= {r_vld[STAGES-2:0], w_accept};
            r_valid <= r_vld[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_typ    <= {r_typ[STAGES-2:0], i_req_type};
        r_pad[0] <= w_res0;
        for (int i = 1; i < PAD; i++) begin
            r_pad[i] <= r_pad[i-1];
        end
        r_status <= n_status;
        r_days   <= n_days;
        r_year   <= n_year;
        r_month  <= n_month;
        r_day    <= n_day;
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_days_out  = r_days;
    assign o_year_out  = r_year;
    assign o_month_out = r_month;
    assign o_day_out   = r_day;

    // Every accepted request shows up exactly once, a fixed time later.
    `CDCU_ASSERT_ALWAYS(a_latency, i_clk, i_rst_n, o_valid == $past(w_accept, cdconv_pkg::LATENCY))

    // A date before the base gives an all-zero result.
    `CDCU_ASSERT_IMP(a_before_zero, i_clk, i_rst_n, o_valid && (o_status == cdconv_pkg::ST_BEFORE), (o_days_out == '0) && (o_year_out == '0) && (o_month_out == '0) && (o_day_out == '0))

    // A converted date lies within the calendar range.
    `CDCU_ASSERT_IMP(a_date_range, i_clk, i_rst_n, o_valid && (o_status == cdconv_pkg::ST_OK) && (o_year_out != '0), (o_days_out == '0) && (o_year_out >= cdconv_pkg::FIRST_YEAR) && (o_year_out <= cdconv_pkg::MAX_YEAR) && (o_month_out >= 4'd1) && (o_month_out <= cdconv_pkg::MAX_MONTH) && (o_day_out >= 5'd1) && (o_day_out <= cdconv_pkg::MAX_DAY))

    // A count past the range saturates to the last date.
    `CDCU_ASSERT_IMP(a_date_sat, i_clk, i_rst_n, o_valid && (o_status == cdconv_pkg::ST_BEYOND) && (o_year_out != '0), (o_year_out == cdconv_pkg::MAX_YEAR) && (o_month_out == cdconv_pkg::MAX_MONTH) && (o_day_out == cdconv_pkg::MAX_DAY))

    // A date past the range saturates to the largest count.
    `CDCU_ASSERT_IMP(a_count_sat, i_clk, i_rst_n, o_valid && (o_status == cdconv_pkg::ST_BEYOND) && (o_year_out == '0), o_days_out == cdconv_pkg::MAX_COUNT)

endmodule

[bench/civil_date_day_count_converter_unit_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// Civil date converter testbench
// Sends date to day count and day count to date requests through the
// command handshake, predicts every result with an independent calendar
// model and compares each strobed result field by field, in request order.
// ============================================================================
module civil_date_day_count_converter_unit_test;

    // Request directions.
    localparam logic REQ_TO_DAYS = 1'b0;
    localparam logic REQ_TO_DATE = 1'b1;

    // Calendar numbers used by the prediction, in plain integers.
    localparam longint SHIFT_TO_EPOCH = 719468;
    localparam longint ERA_DAYS       = 146097;
    localparam longint LAST_COUNT     = 2958463;
    localparam longint LAST_YEAR      = 9999;

    // Random run shape.
    localparam int RANDOM_PHASE_ITEMS = 130;

    // The run ends after this much time no matter what; it is many times the
    // longest correct run, even with every request stalled by the sender.
    localparam int RUN_LIMIT_NS = 2_000_000;

    // One predicted result, held until the block strobes it out.
    typedef struct {
        cdconv_pkg::t_status                 status;
        logic [cdconv_pkg::COUNT_W-1:0]      days;
        logic [cdconv_pkg::YEAR_W-1:0]       year;
        logic [cdconv_pkg::MONTH_W-1:0]      month;
        logic [cdconv_pkg::DAY_W-1:0]        day;
    } t_conversion;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_start = 1'b0;
    logic                               i_req_type = REQ_TO_DAYS;
    logic [cdconv_pkg::YEAR_W-1:0]      i_year = '0;
    logic [cdconv_pkg::MONTH_W-1:0]     i_month = '0;
    logic [cdconv_pkg::DAY_W-1:0]       i_day = '0;
    logic [cdconv_pkg::COUNT_W-1:0]     i_day_count = '0;
    logic                               o_busy;
    logic                               o_valid;
    logic [1:0]                         o_status;
    logic [cdconv_pkg::COUNT_W-1:0]     o_days_out;
    logic [cdconv_pkg::YEAR_W-1:0]      o_year_out;
    logic [cdconv_pkg::MONTH_W-1:0]     o_month_out;
    logic [cdconv_pkg::DAY_W-1:0]       o_day_out;

    // Results still owed by the block, oldest first.
    t_conversion pending_results[$];
    int          error_count = 0;
    // Chance, in percent, that the sender keeps idling after a
    // request has been taken.
    int          sender_idle_pct = 0;

    civil_date_day_count_converter_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req_type  (i_req_type),
        .i_year      (i_year),
        .i_month     (i_month),
        .i_day       (i_day),
        .i_day_count (i_day_count),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_days_out  (o_days_out),
        .o_year_out  (o_year_out),
        .o_month_out (o_month_out),
        .o_day_out   (o_day_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Days from 0000-03-01 shifted to the Unix-style origin, by the era,
    // year-of-era and March-based day-of-year method. Month and day are taken
    // as they come, so out-of-range values simply roll over. Month zero and
    // months one and two belong to the year before in March-based counting.
    function automatic longint civil_day_number(input longint yr, input longint mo,
                                                input longint dy);
        longint era;
        longint yoe;
        longint doy;
        longint doe;
        if (mo <= 2) begin
            yr = yr - 1;
        end
        era = (yr >= 0 ? yr : yr - 399) / 400;
        yoe = yr - era * 400;
        doy = (153 * (mo > 2 ? mo - 3 : mo + 9) + 2) / 5 + dy - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * ERA_DAYS + doe - SHIFT_TO_EPOCH;
    endfunction

    // Expected result of one request. Unused outputs of each direction are
    // zero; results past the range saturate to the last count or the last date.
    function automatic t_conversion convert_civil_request(
        input logic typ, input logic [cdconv_pkg::YEAR_W-1:0] yr,
        input logic [cdconv_pkg::MONTH_W-1:0] mo,
        input logic [cdconv_pkg::DAY_W-1:0] dy,
        input logic [cdconv_pkg::COUNT_W-1:0] cnt);
        t_conversion res;
        longint      base;
        longint      n;
        longint      z;
        longint      era;
        longint      doe;
        longint      yoe;
        longint      y;
        longint      doy;
        longint      mp;
        longint      d;
        longint      m;
        base = civil_day_number(1900, 1, 1);
        res.status = cdconv_pkg::ST_OK;
        res.days = '0;
        res.year = '0;
        res.month = '0;
        res.day = '0;
        if (typ == REQ_TO_DAYS) begin
            n = civil_day_number(longint'(yr), longint'(mo), longint'(dy)) - base;
            if (n < 0) begin
                res.status = cdconv_pkg::ST_BEFORE;
            end else if (n > LAST_COUNT) begin
                res.status = cdconv_pkg::ST_BEYOND;
                res.days = cdconv_pkg::COUNT_W'(LAST_COUNT);
            end else begin
                res.days = cdconv_pkg::COUNT_W'(n);
            end
        end else if (longint'(cnt) > LAST_COUNT) begin
            res.status = cdconv_pkg::ST_BEYOND;
            res.year = cdconv_pkg::YEAR_W'(LAST_YEAR);
            res.month = cdconv_pkg::MONTH_W'(12);
            res.day = cdconv_pkg::DAY_W'(31);
        end else begin
            z = longint'(cnt) + base + SHIFT_TO_EPOCH;
            era = z / ERA_DAYS;
            doe = z - era * ERA_DAYS;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            y = yoe + era * 400;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp = (5 * doy + 2) / 153;
            d = doy - (153 * mp + 2) / 5 + 1;
            m = mp < 10 ? mp + 3 : mp - 9;
            if (m <= 2) begin
                y = y + 1;
            end
            res.year = cdconv_pkg::YEAR_W'(y);
            res.month = cdconv_pkg::MONTH_W'(m);
            res.day = cdconv_pkg::DAY_W'(d);
        end
        return res;
    endfunction

    // A request is taken at an edge where start is high and busy is low; the
    // values seen here are the ones from before that edge.
    always @(posedge i_clk) begin
        if (i_start === 1'b1 && o_busy === 1'b0) begin
            pending_results.push_back(convert_civil_request(i_req_type, i_year, i_month,
                                                            i_day, i_day_count));
        end
    end

    task automatic report_field(input string name, input longint expected,
                                input longint actual);
        if (expected != actual) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $realtime, name, expected, actual);
        end
    endtask

    // Every strobed result must match the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_conversion exp_res;
        if (o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t ns: result with no request outstanding, status %0d",
                         $realtime, o_status);
            end else begin
                exp_res = pending_results.pop_front();
                report_field("status", exp_res.status, o_status);
                report_field("days_out", exp_res.days, o_days_out);
                report_field("year_out", exp_res.year, o_year_out);
                report_field("month_out", exp_res.month, o_month_out);
                report_field("day_out", exp_res.day, o_day_out);
            end
        end
    end

    // Drives one request and holds it until the block takes it. Afterwards
    // the sender may idle, as the current idle rate says.
    // It is entered and left right after a rising edge.
    task automatic send_request(input logic typ,
                                input logic [cdconv_pkg::YEAR_W-1:0] yr,
                                input logic [cdconv_pkg::MONTH_W-1:0] mo,
                                input logic [cdconv_pkg::DAY_W-1:0] dy,
                                input logic [cdconv_pkg::COUNT_W-1:0] cnt);
        i_start <= 1'b1;
        i_req_type <= typ;
        i_year <= yr;
        i_month <= mo;
        i_day <= dy;
        i_day_count <= cnt;
        do begin
            @(posedge i_clk);
        end while (o_busy !== 1'b0);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // The sender stops until every outstanding result has come back.
    task automatic drain_results();
        i_start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_directed_dates();
        // The base date itself and the day just before it.
        send_request(REQ_TO_DAYS, 14'd1900, 4'd1, 5'd1, '0);
        send_request(REQ_TO_DAYS, 14'd1899, 4'd12, 5'd31, '0);
        // Smallest fields: year zero, month zero rolls back into year minus one.
        send_request(REQ_TO_DAYS, 14'd0, 4'd0, 5'd0, '0);
        // Last representable date and the day after it.
        send_request(REQ_TO_DAYS, 14'd9999, 4'd12, 5'd31, '0);
        send_request(REQ_TO_DAYS, 14'd10000, 4'd1, 5'd1, '0);
        // Month thirteen rolls past year 9999; the last date is sent once more.
        send_request(REQ_TO_DAYS, 14'd9999, 4'd13, 5'd1, '0);
        send_request(REQ_TO_DAYS, 14'd9999, 4'd12, 5'd31 + 5'd0, '0);
        // All fields at their top values.
        send_request(REQ_TO_DAYS, 14'd16383, 4'd15, 5'd31, 22'h3FFFFF);
        // Leap day in a leap century, and 1900-02-29 which rolls to March 1.
        send_request(REQ_TO_DAYS, 14'd2000, 4'd2, 5'd29, '0);
        send_request(REQ_TO_DAYS, 14'd1900, 4'd2, 5'd29, '0);
        // Day zero at the base date falls before it; month zero in 1901.
        send_request(REQ_TO_DAYS, 14'd1900, 4'd1, 5'd0, '0);
        send_request(REQ_TO_DAYS, 14'd1901, 4'd0, 5'd31, '0);
    endtask

    task automatic test_directed_counts();
        // First day, the first March, a leap century, and the last valid day.
        send_request(REQ_TO_DATE, '0, '0, '0, 22'd0);
        send_request(REQ_TO_DATE, '0, '0, '0, 22'd59);
        send_request(REQ_TO_DATE, '0, '0, '0, 22'd36583);
        send_request(REQ_TO_DATE, 14'h3FFF, 4'hF, 5'h1F, 22'd2958463);
        // Counts beyond the last date saturate, up to the largest input.
        send_request(REQ_TO_DATE, '0, '0, '0, 22'd2958464);
        send_request(REQ_TO_DATE, '0, '0, '0, 22'h3FFFFF);
        // The last day of a year and the first of the next.
        send_request(REQ_TO_DATE, '0, '0, '0, 22'd36524);
        send_request(REQ_TO_DATE, '0, '0, '0, 22'd36523);
    endtask

    // Mostly well-formed requests with random content; the rest spreads over
    // every value the fields can carry. Unused fields carry random noise.
    task automatic test_random_traffic(input int count, input int idle_pct);
        logic                            typ;
        logic [cdconv_pkg::YEAR_W-1:0]   yr;
        logic [cdconv_pkg::MONTH_W-1:0]  mo;
        logic [cdconv_pkg::DAY_W-1:0]    dy;
        logic [cdconv_pkg::COUNT_W-1:0]  cnt;
        sender_idle_pct = idle_pct;
        repeat (count) begin
            typ = 1'($urandom_range(1));
            yr = cdconv_pkg::YEAR_W'($urandom_range(16383));
            mo = cdconv_pkg::MONTH_W'($urandom_range(15));
            dy = cdconv_pkg::DAY_W'($urandom_range(31));
            cnt = cdconv_pkg::COUNT_W'($urandom_range(22'h3FFFFF));
            if (typ == REQ_TO_DAYS && $urandom_range(99) < 70) begin
                yr = cdconv_pkg::YEAR_W'($urandom_range(9999, 1900));
                mo = cdconv_pkg::MONTH_W'($urandom_range(12, 1));
                dy = cdconv_pkg::DAY_W'($urandom_range(31, 1));
            end else if (typ == REQ_TO_DATE && $urandom_range(99) < 75) begin
                cnt = cdconv_pkg::COUNT_W'($urandom_range(32'(LAST_COUNT)));
            end
            send_request(typ, yr, mo, dy, cnt);
        end
        i_start <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests go back to back, with no idle cycles.
        test_directed_dates();
        test_directed_counts();
        drain_results();

        // Sender idles rarely, then often, then never; the block drains in
        // between so each phase starts from an empty pipeline.
        test_random_traffic(RANDOM_PHASE_ITEMS, 8);
        drain_results();
        test_random_traffic(RANDOM_PHASE_ITEMS, 46);
        drain_results();
        test_random_traffic(RANDOM_PHASE_ITEMS + 10, 0);
        drain_results();

        // Give any stray result time to show up after the last one expected.
        repeat (cdconv_pkg::LATENCY + 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
